// ----- hdl/round_icon_mask_rgb565_unit_macros.svh -----
// Assertion macros for the round icon mask unit.
// Used by rim565_queue and rim565_back; expects i_clk and i_rst_n in scope.
`ifndef ROUND_ICON_MASK_RGB565_UNIT_MACROS_SVH
`define ROUND_ICON_MASK_RGB565_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RIM565_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rim565 check failed");
`define RIM565_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rim565 check failed");
`else
`define RIM565_ASSERT_SAME(lbl, ante, cons)
`define RIM565_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/rim565_pkg.sv -----
// Shared widths, register codes and item type for the round icon mask unit.
// No dependencies.
`default_nettype none

package rim565_pkg;

    localparam int MAX_SIDE_DEF = 1024;

    localparam int H_W     = 11;
    localparam int COORD_W = 10;
    localparam int PIX_W   = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = H_W;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_MODE   = CFG_IDX_W'(1);
    localparam logic [H_W-1:0]       HEIGHT_RESET     = H_W'(64);

    localparam int DY_W       = H_W + 2;
    localparam int SQ_W       = 2 * H_W;
    localparam int D_W        = SQ_W + 1;
    localparam int RAD_W      = D_W + (D_W % 2);
    localparam int FRAC_SHIFT = 16;
    localparam int ROOT_W     = (RAD_W + FRAC_SHIFT) / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int T_W        = ROOT_W + 1;
    localparam int Q_W        = 9;
    localparam logic [Q_W-1:0] FULL_WEIGHT = Q_W'(256);

    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [D_W-1:0]   d;
        logic [PIX_W-1:0] px;
    } t_item;

endpackage

`default_nettype wire

// ----- hdl/rim565_front.sv -----
// Front end: takes pixel transfers, forms the squared distance from the centre.
// Depends on rim565_pkg.
`default_nettype none

module rim565_front #(
    parameter int MAX_SIDE = rim565_pkg::MAX_SIDE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [rim565_pkg::H_W-1:0]     i_height,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [rim565_pkg::COORD_W-1:0] i_row,
    input  wire logic [rim565_pkg::COORD_W-1:0] i_col,
    input  wire logic [rim565_pkg::PIX_W-1:0]   i_px,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output rim565_pkg::t_item                   o_item
);
    import rim565_pkg::*;

    localparam logic [COORD_W-1:0] COORD_KEEP = COORD_W'(MAX_SIDE * 4 - 1);

    logic                    w_en;
    logic [COORD_W-1:0]      w_row;
    logic [COORD_W-1:0]      w_col;
    logic signed [DY_W-1:0]  n_dy;
    logic signed [DY_W-1:0]  n_dx;
    logic signed [2*DY_W-1:0] w_py;
    logic signed [2*DY_W-1:0] w_px2;

    logic [2:0]              r_vld;
    logic signed [DY_W-1:0]  r_dy;
    logic signed [DY_W-1:0]  r_dx;
    logic [SQ_W-1:0]         r_sqy;
    logic [SQ_W-1:0]         r_sqx;
    logic [PIX_W-1:0]        r_px0;
    logic [PIX_W-1:0]        r_px1;
    t_item                   r_item;

    assign w_en    = !r_vld[2] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[2];
    assign o_item  = r_item;

    assign w_row = i_row & COORD_KEEP;
    assign w_col = i_col & COORD_KEEP;
    assign n_dy  = $signed({2'b00, i_height}) - $signed({2'b00, w_row, 1'b0}) - DY_W'(1);
    assign n_dx  = $signed({2'b00, i_height}) - $signed({2'b00, w_col, 1'b0}) - DY_W'(1);
    assign w_py  = r_dy * r_dy;
    assign w_px2 = r_dx * r_dx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
        if (w_en) begin
            r_dy      <= n_dy;
            r_dx      <= n_dx;
            r_px0     <= i_px;
            r_sqy     <= w_py[SQ_W-1:0];
            r_sqx     <= w_px2[SQ_W-1:0];
            r_px1     <= r_px0;
            r_item.d  <= {1'b0, r_sqy} + {1'b0, r_sqx};
            r_item.px <= r_px1;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rim565_queue.sv -----
// Short FIFO between front and back so each side stalls on its own.
// Depends on rim565_pkg and the unit macros header.
`default_nettype none
`include "round_icon_mask_rgb565_unit_macros.svh"

module rim565_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire rim565_pkg::t_item  i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output rim565_pkg::t_item       o_item
);
    import rim565_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_item              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_ready = r_count != CNT_W'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `RIM565_ASSERT_SAME(a_no_push_full, r_count == CNT_W'(Q_DEPTH), !w_push)
    `RIM565_ASSERT_NEXT(a_fill_up, w_push && !w_pop, r_count == $past(r_count) + CNT_W'(1))
    `RIM565_ASSERT_NEXT(a_drain, w_pop && !w_push, r_count == $past(r_count) - CNT_W'(1))

endmodule

`default_nettype wire

// ----- hdl/rim565_back.sv -----
// Back end: pipelined square root, coverage weight and channel blend.
// Depends on rim565_pkg and the unit macros header.
`default_nettype none
`include "round_icon_mask_rgb565_unit_macros.svh"

module rim565_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [rim565_pkg::H_W-1:0]   i_height,
    input  wire logic                         i_night,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire rim565_pkg::t_item            i_item,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [rim565_pkg::PIX_W-1:0]      o_px
);
    import rim565_pkg::*;

    localparam int N = ROOT_W;

    function automatic logic [5:0] mix(input logic [5:0] c, input logic [5:0] fill,
                                       input logic [Q_W-1:0] q);
        logic [14:0] a;
        logic [14:0] b;
        logic [14:0] sum;
        a   = 15'(c) * 15'(q);
        b   = 15'(fill) * 15'(FULL_WEIGHT - q);
        sum = a + b;
        return sum[13:8];
    endfunction

    logic               w_en;
    logic               w_vld  [N];
    logic [REM_W-1:0]   w_rem  [N];
    logic [ROOT_W-1:0]  w_root [N];
    logic [RAD_W-1:0]   w_rad  [N];
    logic [PIX_W-1:0]   w_px   [N];

    logic [N-1:0]       r_vld;
    logic [REM_W-1:0]   r_rem  [N];
    logic [ROOT_W-1:0]  r_root [N];
    logic [RAD_W-1:0]   r_rad  [N];
    logic [PIX_W-1:0]   r_px   [N];

    logic               r_q_vld;
    logic [Q_W-1:0]     r_q;
    logic [PIX_W-1:0]   r_q_px;
    logic               r_out_vld;
    logic [PIX_W-1:0]   r_out_px;

    logic [T_W-1:0]     w_base;
    logic signed [T_W-1:0] w_t;
    logic [T_W-2:0]     w_half;
    logic [Q_W-1:0]     n_q;
    logic [5:0]         w_f5;
    logic [5:0]         w_f6;
    logic [5:0]         w_b;
    logic [5:0]         w_g;
    logic [5:0]         w_r;

    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_out_vld;
    assign o_px    = r_out_px;

    assign w_vld[0]  = i_valid;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rad[0]  = RAD_W'(i_item.d);
    assign w_px[0]   = i_item.px;

    for (genvar k = 0; k < N; k++) begin : g_sqrt
        logic [REM_W+1:0] w_sh;
        logic [REM_W+1:0] w_trial;
        logic             w_ge;
        logic [REM_W+1:0] w_diff;

        if (k > 0) begin : g_link
            assign w_vld[k]  = r_vld[k-1];
            assign w_rem[k]  = r_rem[k-1];
            assign w_root[k] = r_root[k-1];
            assign w_rad[k]  = r_rad[k-1];
            assign w_px[k]   = r_px[k-1];
        end

        assign w_sh    = {w_rem[k], w_rad[k][RAD_W-1:RAD_W-2]};
        assign w_trial = {2'b00, w_root[k], 2'b01};
        assign w_ge    = w_sh >= w_trial;
        assign w_diff  = w_ge ? (w_sh - w_trial) : w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_vld[k] <= w_vld[k];
            end
            if (w_en) begin
                r_rem[k]  <= w_diff[REM_W-1:0];
                r_root[k] <= {w_root[k][ROOT_W-2:0], w_ge};
                r_rad[k]  <= {w_rad[k][RAD_W-3:0], 2'b00};
                r_px[k]   <= w_px[k];
            end
        end
    end

    assign w_base = T_W'({1'b0, i_height} + 12'd1) << 8;
    assign w_t    = $signed(w_base) - $signed({1'b0, r_root[N-1]});
    assign w_half = w_t[T_W-1:1];
    assign n_q    = w_t[T_W-1] ? '0 :
                    (w_half > (T_W-1)'(FULL_WEIGHT)) ? FULL_WEIGHT : w_half[Q_W-1:0];

    assign w_f5 = i_night ? 6'd0 : 6'd31;
    assign w_f6 = i_night ? 6'd0 : 6'd63;
    assign w_b  = mix({1'b0, r_q_px[4:0]}, w_f5, r_q);
    assign w_g  = mix(r_q_px[10:5], w_f6, r_q);
    assign w_r  = mix({1'b0, r_q_px[15:11]}, w_f5, r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_q_vld   <= r_vld[N-1];
            r_out_vld <= r_q_vld;
        end
        if (w_en) begin
            r_q      <= n_q;
            r_q_px   <= r_px[N-1];
            r_out_px <= {w_r[4:0], w_g, w_b[4:0]};
        end
    end

    `RIM565_ASSERT_SAME(a_q_bound, r_q_vld, r_q <= FULL_WEIGHT)
    `RIM565_ASSERT_SAME(a_rem_bound, r_vld[N-1], r_rem[N-1] <= {r_root[N-1], 1'b0})
    `RIM565_ASSERT_NEXT(a_freeze, !w_en, $stable(r_vld) && $stable(r_q_vld))

endmodule

`default_nettype wire

// ----- hdl/round_icon_mask_rgb565_unit.sv -----
// Round icon mask for RGB565 pixels: top level with configuration registers.
// Depends on rim565_pkg, rim565_front, rim565_queue, rim565_back.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready    i_pixel_row, i_pixel_column, i_pixel_in
//   out       output     o_out_valid / i_out_ready  o_pixel_out
//   cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One pixel per clock sustained while the output is not stalled.
// The square root pipeline forms one root bit per stage (20 stages).
// Synchronous active-low reset clears valids and queue pointers and sets the configuration registers to their defaults.
// A 4-entry queue parts front and back; output stall holds the back, and the front once the queue is full.
`default_nettype none

module round_icon_mask_rgb565_unit #(
    parameter int MAX_SIDE = rim565_pkg::MAX_SIDE_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [rim565_pkg::COORD_W-1:0]    i_pixel_row,
    input  wire logic [rim565_pkg::COORD_W-1:0]    i_pixel_column,
    input  wire logic [rim565_pkg::PIX_W-1:0]      i_pixel_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [rim565_pkg::PIX_W-1:0]           o_pixel_out,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rim565_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rim565_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rim565_pkg::*;

    logic [H_W-1:0] r_image_height;
    logic           r_night_mode;

    logic           w_f_valid;
    logic           w_f_ready;
    t_item          w_f_item;
    logic           w_q_valid;
    logic           w_q_ready;
    t_item          w_q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_height <= HEIGHT_RESET;
            r_night_mode   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                CFG_NIGHT_MODE:   r_night_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    rim565_front #(
        .MAX_SIDE(MAX_SIDE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_height (r_image_height),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_row    (i_pixel_row),
        .i_col    (i_pixel_column),
        .i_px     (i_pixel_in),
        .o_valid  (w_f_valid),
        .i_ready  (w_f_ready),
        .o_item   (w_f_item)
    );

    rim565_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_f_valid),
        .o_ready  (w_f_ready),
        .i_item   (w_f_item),
        .o_valid  (w_q_valid),
        .i_ready  (w_q_ready),
        .o_item   (w_q_item)
    );

    rim565_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_height (r_image_height),
        .i_night  (r_night_mode),
        .i_valid  (w_q_valid),
        .o_ready  (w_q_ready),
        .i_item   (w_q_item),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_px     (o_pixel_out)
    );

endmodule

`default_nettype wire

// ----- tb/rim565_checker.sv -----
// Scoreboard for the round icon mask unit: watches the pixel, result and register channels.
// Predicts each blended RGB565 word and compares it in order. Depends on rim565_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rim565_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_ready,
    input  wire logic [rim565_pkg::COORD_W-1:0]    i_pixel_row,
    input  wire logic [rim565_pkg::COORD_W-1:0]    i_pixel_column,
    input  wire logic [rim565_pkg::PIX_W-1:0]      i_pixel_in,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic [rim565_pkg::PIX_W-1:0]      i_pixel_out,
    input  wire logic                              i_cfg_valid,
    input  wire logic                              i_cfg_ready,
    input  wire logic [rim565_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rim565_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                     o_fail_count,
    output int                                     o_pending,
    output int                                     o_checked
);
    import rim565_pkg::*;

    localparam int unsigned WHITE5 = 31;
    localparam int unsigned WHITE6 = 63;

    logic [H_W-1:0]   icon_height;
    logic             night;
    logic [PIX_W-1:0] expected_pixels[$];
    int               mismatches;
    int               checked;

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 23; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic int unsigned fade(input int unsigned c, input int unsigned fill,
                                         input int unsigned q);
        return (c * q + fill * (FULL_WEIGHT - q)) >> 8;
    endfunction

    function automatic logic [PIX_W-1:0] blend_pixel(input logic [H_W-1:0] h,
                                                     input logic dark,
                                                     input logic [COORD_W-1:0] row,
                                                     input logic [COORD_W-1:0] col,
                                                     input logic [PIX_W-1:0] px);
        longint          dy;
        longint          dx;
        longint          t;
        longint unsigned d;
        longint unsigned s;
        longint unsigned half;
        int unsigned     q;
        int unsigned     fill5;
        int unsigned     fill6;
        int unsigned     r;
        int unsigned     g;
        int unsigned     b;
        dy = longint'(h) - 2 * longint'(row) - 1;
        dx = longint'(h) - 2 * longint'(col) - 1;
        d = longint'(dy * dy + dx * dx);
        s = root_floor(d << FRAC_SHIFT);
        t = (longint'(h) + 1) * 256 - longint'(s);
        if (t < 0) begin
            q = 0;
        end else begin
            half = longint'(t >> 1);
            q = (half > FULL_WEIGHT) ? FULL_WEIGHT : int'(half);
        end
        fill5 = dark ? 0 : WHITE5;
        fill6 = dark ? 0 : WHITE6;
        b = fade(px[4:0], fill5, q);
        g = fade(px[10:5], fill6, q);
        r = fade(px[15:11], fill5, q);
        return {r[4:0], g[5:0], b[4:0]};
    endfunction

    always @(posedge i_clk) begin
        logic [PIX_W-1:0] want;
        if (!i_rst_n) begin
            icon_height = HEIGHT_RESET;
            night = 1'b0;
            expected_pixels.delete();
            mismatches = 0;
            checked = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel_out transfer with nothing expected: got %h", i_pixel_out);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (i_pixel_out !== want) begin
                        $error("pixel_out: expected %h, got %h", want, i_pixel_out);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_pixels.insert(expected_pixels.size(),
                                       blend_pixel(icon_height, night, i_pixel_row,
                                                   i_pixel_column, i_pixel_in));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_HEIGHT: icon_height = i_cfg_data;
                    CFG_NIGHT_MODE:   night = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending <= expected_pixels.size();
        o_checked <= checked;
    end

endmodule

`default_nettype wire

// ----- tb/tb_round_icon_mask_rgb565_unit.sv -----
// Top of the round icon mask testbench: clock, reset, pixel and register stimulus, verdict.
// Depends on rim565_pkg, round_icon_mask_rgb565_unit and rim565_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_round_icon_mask_rgb565_unit;
    import rim565_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = CFG_IDX_W'(3);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic [COORD_W-1:0]    i_pixel_row = '0;
    logic [COORD_W-1:0]    i_pixel_column = '0;
    logic [PIX_W-1:0]      i_pixel_in = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_cfg_ready;

    int fail_count;
    int pending;
    int checked;
    int tx_idle_pct = 22;
    int rx_idle_pct = 85;

    always #2 i_clk = ~i_clk;

    round_icon_mask_rgb565_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel_row    (i_pixel_row),
        .i_pixel_column (i_pixel_column),
        .i_pixel_in     (i_pixel_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_out    (o_pixel_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    rim565_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_pixel_row    (i_pixel_row),
        .i_pixel_column (i_pixel_column),
        .i_pixel_in     (i_pixel_in),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_pixel_out    (o_pixel_out),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Called at a clock edge; returns at the edge of the transfer with valid still high.
    task automatic send_pixel(input int row, input int col, input int px);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_pixel_row <= COORD_W'(row);
        i_pixel_column <= COORD_W'(col);
        i_pixel_in <= PIX_W'(px);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_setting(input int h, input int dark);
        drain();
        write_register(CFG_IMAGE_HEIGHT, h);
        write_register(CFG_NIGHT_MODE, dark);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_coord(input int h);
        if ($urandom_range(4) == 0) begin
            return $urandom_range(1023);
        end
        return $urandom_range((h > 1022) ? 1023 : h + 1);
    endfunction

    initial begin
        int h;
        int wait_cycles;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: corner, centre, edges, pixel beyond the icon
        send_pixel(0, 0, 16'hFFFF);
        send_pixel(32, 32, 16'h0000);
        send_pixel(31, 31, 16'hF800);
        send_pixel(0, 32, 16'h07E0);
        send_pixel(32, 0, 16'h001F);
        send_pixel(1023, 1023, 16'h0000);
        send_pixel(10, 5, $urandom_range(16'hFFFF));
        // zero height, black fill
        apply_setting(0, 1);
        send_pixel(0, 0, 16'hFFFF);
        send_pixel(1023, 0, 16'hFFFF);
        // height beyond the nominal range
        apply_setting(2047, 0);
        send_pixel(1023, 1023, 16'hFFFF);
        send_pixel(0, 0, 16'h0000);
        send_pixel(1023, 0, 16'hABCD);
        apply_setting(1, 1);
        send_pixel(0, 0, 16'hFFFF);
        send_pixel(0, 1, 16'hFFFF);
        send_pixel(1, 1, 16'h1234);
        // unused indices must leave both registers alone
        drain();
        write_register(CFG_IDX_UNUSED_LO, 11'h7FF);
        write_register(CFG_IDX_UNUSED_HI, 11'h000);
        i_cfg_valid <= 1'b0;
        send_pixel(0, 0, 16'hFFFF);
        // night mode takes bit 0 only
        drain();
        write_register(CFG_IMAGE_HEIGHT, 1024);
        write_register(CFG_NIGHT_MODE, 11'h7FE);
        i_cfg_valid <= 1'b0;
        send_pixel(512, 512, 16'hFFFF);
        send_pixel(0, 0, 16'h0000);

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 85 : 0;
            rx_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 22 : 0;
            for (int setting = 0; setting < 6; setting++) begin
                case (setting)
                    0:       h = 1024;
                    1:       h = 1;
                    2:       h = $urandom_range(1) ? 0 : 2047;
                    3:       h = $urandom_range(2, 40);
                    default: h = $urandom_range(2, 1024);
                endcase
                apply_setting(h, (setting + phase) % 2);
                for (int n = 0; n < 92; n++) begin
                    send_pixel(pick_coord(h), pick_coord(h), $urandom_range(16'hFFFF));
                    if (n == 46 && setting % 3 == 0) begin
                        drain();
                    end
                end
            end
        end

        i_in_valid <= 1'b0;
        for (wait_cycles = 0; pending != 0 && wait_cycles < 5000; wait_cycles++) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        $display("Checked %0d pixels: heights 0, 1, 1024 and 2047 plus random ones, both fills,",
                 checked);
        $display("unused register indices, and sender and receiver stalls in turn and not at all.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/rim565_pkg.sv
hdl/rim565_front.sv
hdl/rim565_queue.sv
hdl/rim565_back.sv
hdl/round_icon_mask_rgb565_unit.sv
tb/rim565_checker.sv
tb/tb_round_icon_mask_rgb565_unit.sv
